@@ rtl/fram_pkg.sv @@
// Package for the four-register ALU machine: sizes, word type and command codes.
// Used by fram_ram users and by four_register_alu_machine_unit; no dependencies.
package fram_pkg;

  localparam int NUM_REGS   = 4;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_MOVE = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_DIV  = 3'd5,
    CMD_OUT  = 3'd6
  } cmd_e;

endpackage

@@ rtl/fram_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fram_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/four_register_alu_machine_unit.sv @@
// Top level of the four-register ALU machine: sequencer, shared adder, output register.
// Depends on fram_pkg and fram_ram.
//
//  channel | direction | payload                                   | handshake
//  in      | input     | command, dest_reg, src_reg, immediate     | in_valid_i / in_stall_o
//  out     | output    | value, is_error                           | out_valid_o / out_stall_i
//
// One shared DATA_WIDTH+1 bit adder does all arithmetic. An item first reads both registers
// from the register RAM, then executes: load/move/add/sub, output, refused divide, multiply
// (one partial product per cycle) and divide (one quotient bit per cycle). Reset clears the
// register file through per-entry valid bits. A result waits while the output register
// is full and out_stall_i is high; the input side stays stalled until the pending result
// is in the output register.
module four_register_alu_machine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [1:0]         dest_reg_i,
  input  logic [1:0]         src_reg_i,
  input  logic signed [31:0] immediate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               is_error_o
);

  localparam int DW = fram_pkg::DATA_WIDTH;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_S, ST_RD_D, ST_EXEC, ST_MUL, ST_DIV_DEN, ST_DIV, ST_DIV_FIX, ST_WB, ST_RESP
  } state_e;

  state_e                      state_q, state_d;
  fram_pkg::cmd_e              cmd_q, cmd_d;
  logic [1:0]                  di_q, di_d, si_q, si_d;
  logic [31:0]                 imm_q, imm_d;
  fram_pkg::word_t             d_q, d_d, s_q, s_d, res_q, res_d;
  fram_pkg::cnt_t              cnt_q, cnt_d;
  logic                        neg_q, neg_d;
  logic                        err_q, err_d;
  logic [fram_pkg::NUM_REGS-1:0] vld_q, vld_d;
  fram_pkg::addr_t             raddr_q, raddr_d;
  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 val_q, val_d;
  logic                        out_err_q, out_err_d;

  logic                        in_xfer, out_xfer;
  logic                        ram_we;
  fram_pkg::word_t             ram_rdata, rd_word;
  logic [DW:0]                 add_a, add_b, add_sum;
  logic                        add_sub;
  fram_pkg::word_t             div_sh;
  logic                        idx_ok;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign ram_we   = (state_q == ST_WB);
  assign rd_word  = vld_q[raddr_q] ? ram_rdata : '0;
  assign div_sh   = {res_q[DW-2:0], d_q[DW-1]};
  assign idx_ok   = (int'(di_q) < fram_pkg::NUM_REGS) && (int'(si_q) < fram_pkg::NUM_REGS);

  fram_ram #(
    .WIDTH (DW),
    .DEPTH (fram_pkg::NUM_REGS)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fram_pkg::ADDR_W'(di_q)),
    .wdata_i (res_q),
    .raddr_i (raddr_d),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    add_a   = '0;
    add_b   = {1'b0, s_q};
    add_sub = 1'b0;
    case (state_q)
      ST_EXEC: begin
        if (cmd_q == fram_pkg::CMD_DIV) begin
          add_b   = {1'b0, d_q};
          add_sub = 1'b1;
        end else begin
          add_a   = {1'b0, d_q};
          add_sub = (cmd_q == fram_pkg::CMD_SUB);
        end
      end
      ST_MUL: begin
        add_a = {1'b0, res_q};
        add_b = {1'b0, d_q};
      end
      ST_DIV_DEN: begin
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = {1'b0, div_sh};
        add_sub = 1'b1;
      end
      ST_DIV_FIX: begin
        add_b   = {1'b0, d_q};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + (DW+1)'(add_sub);
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    di_d        = di_q;
    si_d        = si_q;
    imm_d       = imm_q;
    d_d         = d_q;
    s_d         = s_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    err_d       = err_q;
    vld_d       = vld_q;
    raddr_d     = fram_pkg::ADDR_W'(di_q);
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    val_d       = val_q;
    out_err_d   = out_err_q;
    case (state_q)
      ST_IDLE: begin
        raddr_d = fram_pkg::ADDR_W'(src_reg_i);
        if (in_xfer) begin
          cmd_d   = fram_pkg::cmd_e'(command_i);
          di_d    = dest_reg_i;
          si_d    = src_reg_i;
          imm_d   = immediate_i;
          state_d = ST_RD_S;
        end
      end
      ST_RD_S: begin
        s_d     = rd_word;
        state_d = ST_RD_D;
      end
      ST_RD_D: begin
        d_d     = rd_word;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (idx_ok) begin
          case (cmd_q)
            fram_pkg::CMD_LOAD: begin
              res_d   = DW'($signed(imm_q));
              state_d = ST_WB;
            end
            fram_pkg::CMD_MOVE: begin
              res_d   = s_q;
              state_d = ST_WB;
            end
            fram_pkg::CMD_ADD, fram_pkg::CMD_SUB: begin
              res_d   = add_sum[DW-1:0];
              state_d = ST_WB;
            end
            fram_pkg::CMD_MUL: begin
              res_d   = '0;
              cnt_d   = fram_pkg::CNT_W'(DW - 1);
              state_d = ST_MUL;
            end
            fram_pkg::CMD_DIV: begin
              if (s_q == '0) begin
                res_d   = '0;
                err_d   = 1'b1;
                state_d = ST_RESP;
              end else begin
                neg_d   = d_q[DW-1] ^ s_q[DW-1];
                if (d_q[DW-1]) begin
                  d_d = add_sum[DW-1:0];
                end
                state_d = ST_DIV_DEN;
              end
            end
            fram_pkg::CMD_OUT: begin
              res_d   = d_q;
              err_d   = 1'b0;
              state_d = ST_RESP;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (s_q[0]) begin
          res_d = add_sum[DW-1:0];
        end
        d_d   = {d_q[DW-2:0], 1'b0};
        s_d   = {1'b0, s_q[DW-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_WB;
        end
      end
      ST_DIV_DEN: begin
        if (s_q[DW-1]) begin
          s_d = add_sum[DW-1:0];
        end
        res_d   = '0;
        cnt_d   = fram_pkg::CNT_W'(DW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        res_d = add_sum[DW] ? div_sh : add_sum[DW-1:0];
        d_d   = {d_q[DW-2:0], !add_sum[DW]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        res_d   = neg_q ? add_sum[DW-1:0] : d_q;
        state_d = ST_WB;
      end
      ST_WB: begin
        vld_d[di_q] = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          val_d       = 32'(res_q);
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      raddr_q     <= '0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      raddr_q     <= raddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    di_q      <= di_d;
    si_q      <= si_d;
    imm_q     <= imm_d;
    d_q       <= d_d;
    s_q       <= s_d;
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    err_q     <= err_d;
    val_q     <= val_d;
    out_err_q <= out_err_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(val_q);
  assign is_error_o  = out_err_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_error_o |-> value_o == '0)
    else $error("error result with nonzero value");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_wb_not_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> in_stall_o && !in_xfer)
    else $error("register write while idle");

  a_resp_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RESP && out_valid_q && out_stall_i |=> state_q == ST_RESP)
    else $error("result left the sequencer while the output was held");

endmodule
